FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/sic_pkg.sv
package sic_pkg;

   // event codes on req_data.func
   localparam logic [2:0] FUNC_START  = 3'd0;
   localparam logic [2:0] FUNC_SAMPLE = 3'd1;
   localparam logic [2:0] FUNC_EXIT   = 3'd2;
   localparam logic [2:0] FUNC_HOME   = 3'd3;
   localparam logic [2:0] FUNC_PAUSE  = 3'd4;

   // material codes
   localparam logic [1:0] CLASS_WHITE    = 2'd0;
   localparam logic [1:0] CLASS_BLACK    = 2'd1;
   localparam logic [1:0] CLASS_ALUMINUM = 2'd2;
   localparam logic [1:0] CLASS_STEEL    = 2'd3;

   // error codes
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_STEEL = 2'd0;
   localparam logic [1:0] CSR_WHITE = 2'd1;
   localparam logic [1:0] CSR_BLACK = 2'd2;

   localparam logic [9:0] STEEL_THR_RESET = 10'd351;
   localparam logic [9:0] WHITE_THR_RESET = 10'd700;
   localparam logic [9:0] BLACK_THR_RESET = 10'd941;

   // back-end command opcodes
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_PUSH  = 3'd1;
   localparam logic [2:0] OP_POP   = 3'd2;
   localparam logic [2:0] OP_HOME  = 3'd3;
   localparam logic [2:0] OP_PAUSE = 3'd4;

   localparam logic [6:0] STEPS_NONE    = 7'd0;
   localparam logic [6:0] STEPS_QUARTER = 7'd50;
   localparam logic [6:0] STEPS_HALF    = 7'd100;

   localparam int CMDQ_DEPTH = 2;

   typedef struct packed {
      logic [2:0] func;
      logic [9:0] sample;
      logic       still_present;
   } req_type;

   typedef struct packed {
      logic       classified;
      logic [1:0] class_code;
      logic       dispatched;
      logic [1:0] bin_code;
      logic [6:0] rotate_steps;
      logic       rotate_ccw;
      logic [1:0] tray_now;
      logic [4:0] queue_count;
      logic [15:0] bin_total;
      logic [1:0] error_code;
      logic       motor_run;
   } rsp_type;

   typedef struct packed {
      logic [9:0] steel;
      logic [9:0] white;
      logic [9:0] black;
   } thr_type;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] code;
   } cmd_type;

   typedef struct packed {
      logic [6:0] steps;
      logic       ccw;
   } turn_type;

   // Tray move from position 'from' to bin 'to'.
   function automatic turn_type plan_turn(input logic [1:0] from, input logic [1:0] to);
      turn_type t;
      t.steps = STEPS_NONE;
      t.ccw   = 1'b0;
      case ({from, to})
         4'b00_01, 4'b01_00, 4'b10_11, 4'b11_10: t.steps = STEPS_HALF;
         4'b00_11, 4'b01_10, 4'b10_00, 4'b11_01: t.steps = STEPS_QUARTER;
         4'b00_10, 4'b01_11, 4'b10_01, 4'b11_00: begin
            t.steps = STEPS_QUARTER;
            t.ccw   = 1'b1;
         end
         default: ;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/core/conveyor_item_sorter_top.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | req_data (req_type: func, sample, still_present)
// rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type: one result per event)
// csr     | in        | csr_valid/csr_ready  | csr_index (2b), csr_data (10b threshold)
//
// One event per cycle unless rsp stalls; a result goes through a command queue slot and the
// result register to rsp. Throughput is set by the back end, which retires one command
// per cycle unless rsp stalls, from the two-entry command queue into the result register.
// Reset is synchronous: thresholds reload 351/700/941, minimum to all ones,
// belt queue empty, tray 0, motor running, bin counters zero. No clearing pass.
// A stalled rsp fills the command queue, then req_ready drops; csr is always ready.
module conveyor_item_sorter_top
   import sic_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int COUNT_BITS  = 16,
   parameter int SAMPLE_BITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_data
);

   thr_type thr_ff, thr_in;

   // front -> queue, queue -> back
   logic    fq_valid, fq_ready;
   cmd_type fq_cmd;
   logic    qb_valid, qb_ready;
   cmd_type qb_cmd;

   // threshold registers; a transfer to an unused index is ignored
   assign csr_ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STEEL: thr_in.steel = csr_data;
            CSR_WHITE: thr_in.white = csr_data;
            CSR_BLACK: thr_in.black = csr_data;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.steel <= STEEL_THR_RESET;
         thr_ff.white <= WHITE_THR_RESET;
         thr_ff.black <= BLACK_THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // front: tracks the running minimum and classifies finished items
   sic_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .thr       (thr_ff),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd       (fq_cmd)
   );

   // decouples the front from back-end/result stalls
   sic_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   // back: belt FIFO, tray, pause and bin counters; registers the result
   sic_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd       (qb_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/sic_cmdq.sv
module sic_cmdq
   import sic_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PtrBits = $clog2(CMDQ_DEPTH);
   localparam int CntBits = $clog2(CMDQ_DEPTH + 1);

   cmd_type              slot_ff [CMDQ_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign push_ready = cnt_ff != CntBits'(CMDQ_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/sic_front.sv
module sic_front
   import sic_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  thr_type thr,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd
);

   localparam int CmpBits = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;

   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] smp;
   logic [CmpBits-1:0]     min_cmp;
   logic                   take;
   logic [1:0]             code;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign take      = req_valid && req_ready;
   assign smp       = (SAMPLE_BITS)'(req_data.sample);

   always_comb begin
      min_in = min_ff;
      unique case (req_data.func)
         FUNC_START:  min_in = '1;
         FUNC_SAMPLE: min_in = (smp < min_ff) ? smp : min_ff;
         default:     ;
      endcase
   end

   // classify on the updated minimum
   assign min_cmp = (CmpBits)'(min_in);
   always_comb begin
      if (min_cmp < (CmpBits)'(thr.steel)) begin
         code = CLASS_ALUMINUM;
      end else if (min_cmp < (CmpBits)'(thr.white)) begin
         code = CLASS_STEEL;
      end else if (min_cmp < (CmpBits)'(thr.black)) begin
         code = CLASS_WHITE;
      end else begin
         code = CLASS_BLACK;
      end
   end

   always_comb begin
      cmd.code = code;
      unique case (req_data.func)
         FUNC_SAMPLE: cmd.op = req_data.still_present ? OP_NONE : OP_PUSH;
         FUNC_EXIT:   cmd.op = OP_POP;
         FUNC_HOME:   cmd.op = OP_HOME;
         FUNC_PAUSE:  cmd.op = OP_PAUSE;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '1;
      end else if (take) begin
         min_ff <= min_in;
      end
   end

endmodule

FILE: rtl/core/sic_back.sv
`include "assert_macros.svh"
module sic_back
   import sic_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PtrBits  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FillBits = $clog2(QUEUE_DEPTH + 1);
   localparam int SumBits  = $clog2(2 * QUEUE_DEPTH);

   logic [1:0]            mem [QUEUE_DEPTH];
   logic [1:0]            rd_ff;
   logic                  byp_ff, byp_in;
   logic [1:0]            byp_code_ff;
   logic [1:0]            head_code;

   logic [PtrBits-1:0]    head_ff, head_in;
   logic [PtrBits-1:0]    tail_ff, tail_in;
   logic [FillBits-1:0]   fill_ff, fill_in;
   logic [1:0]            tray_ff, tray_in;
   logic                  paused_ff, paused_in;
   logic [COUNT_BITS-1:0] cnt_ff [4];
   logic [COUNT_BITS-1:0] cnt_sel, cnt_inc;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  take, wr_en, cnt_en;
   turn_type              turn;
   logic [SumBits-1:0]    tail_chk_sum;
   logic [PtrBits-1:0]    tail_chk;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign head_code = byp_ff ? byp_code_ff : rd_ff;
   assign cnt_sel   = cnt_ff[head_code];
   assign cnt_inc   = (cnt_sel == '1) ? cnt_sel : cnt_sel + 1'b1;
   assign turn      = plan_turn(tray_ff, head_code);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      tray_in   = tray_ff;
      paused_in = paused_ff;
      wr_en     = 1'b0;
      cnt_en    = 1'b0;
      rsp_in    = '0;
      if (take) begin
         unique case (cmd.op)
            OP_PUSH: begin
               rsp_in.class_code = cmd.code;
               if (fill_ff < FillBits'(QUEUE_DEPTH)) begin
                  wr_en             = 1'b1;
                  tail_in           = (tail_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0
                                                                             : tail_ff + 1'b1;
                  fill_in           = fill_ff + 1'b1;
                  rsp_in.classified = 1'b1;
               end else begin
                  rsp_in.error_code = ERR_FULL;
               end
            end
            OP_POP: begin
               if (fill_ff == '0) begin
                  rsp_in.error_code = ERR_EMPTY;
               end else begin
                  head_in             = (head_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0
                                                                               : head_ff + 1'b1;
                  fill_in             = fill_ff - 1'b1;
                  tray_in             = head_code;
                  cnt_en              = 1'b1;
                  rsp_in.dispatched   = 1'b1;
                  rsp_in.bin_code     = head_code;
                  rsp_in.rotate_steps = turn.steps;
                  rsp_in.rotate_ccw   = turn.ccw;
                  rsp_in.bin_total    = 16'(cnt_inc);
               end
            end
            OP_HOME:  tray_in   = CLASS_BLACK;
            OP_PAUSE: paused_in = !paused_ff;
            default:  ;
         endcase
      end
      rsp_in.tray_now    = tray_in;
      rsp_in.queue_count = 5'(fill_in);
      rsp_in.motor_run   = !paused_in;
   end

   // read-during-write at the head slot returns old data; forward the new code
   assign byp_in = wr_en && (tail_ff == head_in);

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         tray_ff      <= '0;
         paused_ff    <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         tray_ff      <= tray_in;
         paused_ff    <= paused_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_en) begin
            cnt_ff[head_code] <= cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= cmd.code;
      end
      rd_ff       <= mem[head_in];
      byp_code_ff <= cmd.code;
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   // expected tail from head and fill
   assign tail_chk_sum = SumBits'(head_ff) + SumBits'(fill_ff);
   assign tail_chk     = (tail_chk_sum >= SumBits'(QUEUE_DEPTH))
                         ? PtrBits'(tail_chk_sum - SumBits'(QUEUE_DEPTH))
                         : PtrBits'(tail_chk_sum);

   `ASSERT_CLK(a_fill_bound, clock, reset, fill_ff <= FillBits'(QUEUE_DEPTH), "fill overflow")
   `ASSERT_CLK(a_tail_track, clock, reset, tail_ff == tail_chk, "tail out of step with head+fill")
   `ASSERT_IMPLY(a_dispatch_tray, clock, reset, rsp_valid_ff && rsp_ff.dispatched,
                 rsp_ff.tray_now == rsp_ff.bin_code && rsp_ff.error_code == ERR_OK,
                 "dispatch left tray off bin")

endmodule
